[rtl/qled_pkg.sv]
// Package for the quoted literal escape decoder.
// Holds the transaction types, the decoder state type, result kinds and helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qled_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       raw_request;
    } src_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] byte_value;
        logic       last;
    } res_t;

    localparam logic [2:0] K_BYTE    = 3'd0;
    localparam logic [2:0] K_STR     = 3'd1;
    localparam logic [2:0] K_RAW     = 3'd2;
    localparam logic [2:0] K_CHAR    = 3'd3;
    localparam logic [2:0] K_UNTERM  = 3'd4;
    localparam logic [2:0] K_BADESC  = 3'd5;
    localparam logic [2:0] K_CHARLEN = 3'd6;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BODY  = 3'd1,
        PH_ESC   = 3'd2,
        PH_XPEND = 3'd3,
        PH_OCT   = 3'd4,
        PH_HEX   = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic       quote_is_single;
        logic       raw_mode;
        logic [7:0] escape_accum;
        logic [1:0] octal_digits;
        logic [1:0] byte_count;
        logic [7:0] first_byte;
    } dec_state_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // {valid, value}
    function automatic logic [8:0] letter_escape(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        unique case (c)
            8'h6e:   r = {1'b1, 8'd10};
            8'h74:   r = {1'b1, 8'd9};
            8'h72:   r = {1'b1, 8'd13};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h61:   r = {1'b1, 8'd7};
            8'h76:   r = {1'b1, 8'd11};
            8'h65:   r = {1'b1, 8'd27};
            8'h5c:   r = {1'b1, 8'h5c};
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3f:   r = {1'b1, 8'h3f};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Byte counting for char literal length check; count saturates at 2.
    function automatic dec_state_t count_byte(input dec_state_t s, input logic [7:0] b);
        dec_state_t r;
        r = s;
        if (s.byte_count == 2'd0) begin
            r.first_byte = b;
        end
        if (s.byte_count < 2'd2) begin
            r.byte_count = s.byte_count + 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/qled_step.sv]
// Next-state and result decode for one source character.
// Depends on qled_pkg. Produces up to two results per character.
`timescale 1ns / 1ps
`default_nettype none

module qled_step
    import qled_pkg::*;
(
    input  wire dec_state_t cur,
    input  wire src_t       src,
    output dec_state_t      nxt,
    output logic            v0,
    output res_t            r0,
    output logic            v1,
    output res_t            r1
);

    logic       do_body;
    logic [4:0] hx;
    logic [8:0] le;
    logic       is_oct;
    logic [7:0] q;
    logic       bv;
    res_t       br;

    always_comb
    begin
        nxt     = cur;
        v0      = 1'b0;
        r0      = '0;
        v1      = 1'b0;
        r1      = '0;
        do_body = 1'b0;
        hx      = hex_value(src.ch);
        le      = letter_escape(src.ch);
        is_oct  = (src.ch >= CH_ZERO) && (src.ch <= CH_SEVEN);
        bv      = 1'b0;
        br      = '0;
        q       = CH_DQUOTE;

        unique case (cur.phase)
            PH_IDLE:
            begin
                if (src.ch == CH_DQUOTE || src.ch == CH_SQUOTE) begin
                    nxt.quote_is_single = (src.ch == CH_SQUOTE);
                    nxt.raw_mode        = src.raw_request;
                    nxt.escape_accum    = 8'd0;
                    nxt.octal_digits    = 2'd0;
                    nxt.byte_count      = 2'd0;
                    nxt.first_byte      = 8'd0;
                    nxt.phase           = PH_BODY;
                end
            end
            PH_BODY:
            begin
                do_body = 1'b1;
            end
            PH_ESC:
            begin
                if (src.ch == 8'd0) begin
                    nxt.phase = PH_IDLE;
                    v0 = 1'b1;
                    r0 = '{result_kind: K_UNTERM, byte_value: 8'd0, last: 1'b1};
                end else if (is_oct) begin
                    nxt.escape_accum = {5'd0, src.ch[2:0]};
                    nxt.octal_digits = 2'd1;
                    nxt.phase        = PH_OCT;
                end else if (src.ch == CH_X) begin
                    nxt.phase = PH_XPEND;
                end else if (!le[8]) begin
                    nxt.phase = PH_IDLE;
                    v0 = 1'b1;
                    r0 = '{result_kind: K_BADESC, byte_value: 8'd0, last: 1'b1};
                end else begin
                    nxt       = count_byte(nxt, le[7:0]);
                    nxt.phase = PH_BODY;
                    v0 = 1'b1;
                    r0 = '{result_kind: K_BYTE, byte_value: le[7:0], last: 1'b0};
                end
            end
            PH_XPEND:
            begin
                if (!hx[4]) begin
                    nxt.phase = PH_IDLE;
                    v0 = 1'b1;
                    r0 = '{result_kind: K_BADESC, byte_value: 8'd0, last: 1'b1};
                end else begin
                    nxt.escape_accum = {4'd0, hx[3:0]};
                    nxt.phase        = PH_HEX;
                end
            end
            PH_OCT:
            begin
                if (is_oct) begin
                    nxt.escape_accum = {cur.escape_accum[4:0], src.ch[2:0]};
                    if (cur.octal_digits >= 2'd2) begin
                        nxt.octal_digits = 2'd0;
                        nxt.phase        = PH_BODY;
                        nxt = count_byte(nxt, nxt.escape_accum);
                        v0 = 1'b1;
                        r0 = '{result_kind: K_BYTE, byte_value: nxt.escape_accum, last: 1'b0};
                    end else begin
                        nxt.octal_digits = cur.octal_digits + 2'd1;
                    end
                end else begin
                    nxt.octal_digits = 2'd0;
                    nxt.phase        = PH_BODY;
                    nxt = count_byte(nxt, cur.escape_accum);
                    v0 = 1'b1;
                    r0 = '{result_kind: K_BYTE, byte_value: cur.escape_accum, last: 1'b0};
                    do_body = 1'b1;
                end
            end
            PH_HEX:
            begin
                if (hx[4]) begin
                    nxt.escape_accum = {cur.escape_accum[3:0], hx[3:0]};
                end else begin
                    nxt.phase = PH_BODY;
                    nxt = count_byte(nxt, cur.escape_accum);
                    v0 = 1'b1;
                    r0 = '{result_kind: K_BYTE, byte_value: cur.escape_accum, last: 1'b0};
                    do_body = 1'b1;
                end
            end
            default:
            begin
                nxt.phase = PH_IDLE;
            end
        endcase

        // Body character handling, after any flushed escape byte.
        if (do_body) begin
            q = nxt.quote_is_single ? CH_SQUOTE : CH_DQUOTE;
            if (src.ch == q) begin
                bv = 1'b1;
                nxt.phase = PH_IDLE;
                if (nxt.raw_mode) begin
                    br = '{result_kind: K_RAW, byte_value: 8'd0, last: 1'b1};
                end else if (nxt.quote_is_single) begin
                    if (nxt.byte_count == 2'd1) begin
                        br = '{result_kind: K_CHAR, byte_value: nxt.first_byte, last: 1'b1};
                    end else begin
                        br = '{result_kind: K_CHARLEN, byte_value: 8'd0, last: 1'b1};
                    end
                end else begin
                    br = '{result_kind: K_STR, byte_value: 8'd0, last: 1'b1};
                end
            end else if (src.ch == 8'd0) begin
                bv = 1'b1;
                nxt.phase = PH_IDLE;
                br = '{result_kind: K_UNTERM, byte_value: 8'd0, last: 1'b1};
            end else if (!nxt.raw_mode && src.ch == CH_BSLASH) begin
                nxt.phase = PH_ESC;
            end else begin
                bv  = 1'b1;
                nxt = count_byte(nxt, src.ch);
                br  = '{result_kind: K_BYTE, byte_value: src.ch, last: 1'b0};
            end

            if (bv) begin
                if (v0) begin
                    v1 = 1'b1;
                    r1 = br;
                end else begin
                    v0 = 1'b1;
                    r0 = br;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/quoted_literal_escape_decoder.sv]
// Results enter the result queue when their character is accepted and are offered from its head.
// Throughput: one character per cycle while results are taken at least as fast; a
// character giving two results needs two output transactions, set by the 4-entry result queue.
// Input stalls whenever the queue has fewer than two free entries.
// Reset (rst_n low, asynchronous) returns the decoder to idle and empties the queue.
// Depends on qled_pkg and qled_step.
`timescale 1ns / 1ps
`default_nettype none

module quoted_literal_escape_decoder
    import qled_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        src_valid,
    output logic       src_stall,
    input  wire src_t  src_data,
    output logic       res_valid,
    input  wire        res_stall,
    output res_t       res_data
);

    dec_state_t state_reg;
    dec_state_t state_next;
    logic       v0;
    logic       v1;
    res_t       r0;
    res_t       r1;

    res_t       q_mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    logic       src_acc;
    logic       res_acc;
    logic       push0;
    logic       push1;

    qled_step u_step (
        .cur (state_reg),
        .src (src_data),
        .nxt (state_next),
        .v0  (v0),
        .r0  (r0),
        .v1  (v1),
        .r1  (r1)
    );

    assign src_stall = (count_reg > 3'd2);
    assign src_acc   = src_valid && !src_stall;
    assign res_valid = (count_reg != 3'd0);
    assign res_acc   = res_valid && !res_stall;
    assign res_data  = q_mem[rd_ptr_reg];
    assign push0     = src_acc && v0;
    assign push1     = src_acc && v1;

    assign count_next = count_reg + {2'd0, push0} + {2'd0, push1} - {2'd0, res_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= '{phase: PH_IDLE, default: '0};
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (src_acc) begin
                state_reg <= state_next;
            end
            if (push0 && push1) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd2;
            end else if (push0) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (res_acc) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0) begin
            q_mem[wr_ptr_reg] <= r0;
        end
        if (push1) begin
            q_mem[wr_ptr_reg + 2'd1] <= r1;
        end
    end

endmodule

`default_nettype wire
